// ===== rtl/sorted_line_index_table_assert.svh =====
// Assertion macros used by the RTL of the sorted line index table.
`ifndef SORTED_LINE_INDEX_TABLE_ASSERT_SVH
`define SORTED_LINE_INDEX_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_line_index_table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_line_index_table: next-cycle check failed");

`endif

// ===== rtl/sli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    localparam int MAX_LINES = 1024;
    localparam int ADDR_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = 11;
    localparam int KEY_W     = 31;
    localparam int OFS_W     = 32;
    localparam int LEN_W     = 16;
    localparam int HASH_W    = 32;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_cnt MAX_CNT = CNT_W'(MAX_LINES);

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_DELETED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADPOS   = 3'd5
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [OFS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic [HASH_W-1:0] hash;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   re;
        t_addr  raddr;
        logic   we;
        t_addr  waddr;
        t_entry wdata;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_cnt    position;
        t_cnt    count;
        t_entry  data;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sli_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/sli_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_line_index_table_assert.svh"

module sli_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire sli_pkg::t_cmd     i_cmd,
    input  wire sli_pkg::t_entry   i_entry,
    input  wire sli_pkg::t_addr    i_read_position,
    output sli_pkg::t_mem_req      o_mem,
    input  wire sli_pkg::t_entry   i_rdata,
    output logic                   o_res_valid,
    output sli_pkg::t_result       o_res,
    input  wire logic              i_res_take
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SEARCH    = 10'b00_0000_0010,
        S_COMPARE   = 10'b00_0000_0100,
        S_UP_RD     = 10'b00_0000_1000,
        S_UP_WR     = 10'b00_0001_0000,
        S_PUT_WR    = 10'b00_0010_0000,
        S_DN_RD     = 10'b00_0100_0000,
        S_DN_WR     = 10'b00_1000_0000,
        S_READ_WAIT = 10'b01_0000_0000,
        S_REPLY     = 10'b10_0000_0000
    } t_state;

    t_state           r_state, n_state;
    sli_pkg::t_cnt    r_count, n_count;
    sli_pkg::t_cmd    r_cmd, n_cmd;
    sli_pkg::t_entry  r_new, n_new;
    sli_pkg::t_entry  r_data, n_data;
    sli_pkg::t_cnt    r_lo, n_lo;
    sli_pkg::t_cnt    r_hi, n_hi;
    sli_pkg::t_cnt    r_ptr, n_ptr;
    sli_pkg::t_cnt    r_pos, n_pos;
    logic             r_hit, n_hit;
    sli_pkg::t_status r_status, n_status;

    logic [sli_pkg::CNT_W:0] w_sum;
    sli_pkg::t_cnt           w_mid;
    sli_pkg::t_cnt           w_mid_inc;
    sli_pkg::t_cnt           w_lo_inc;
    sli_pkg::t_cnt           w_ptr_dec;
    sli_pkg::t_cnt           w_ptr_inc;
    sli_pkg::t_cnt           w_ptr_inc2;
    sli_pkg::t_cnt           w_read_pos;
    logic                    w_insert_wr;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[sli_pkg::CNT_W:1];
    assign w_mid_inc  = w_mid + sli_pkg::CNT_W'(1);
    assign w_lo_inc   = r_lo + sli_pkg::CNT_W'(1);
    assign w_ptr_dec  = r_ptr - sli_pkg::CNT_W'(1);
    assign w_ptr_inc  = r_ptr + sli_pkg::CNT_W'(1);
    assign w_ptr_inc2 = r_ptr + sli_pkg::CNT_W'(2);
    assign w_read_pos = sli_pkg::CNT_W'(i_read_position);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_new    = r_new;
        n_data   = r_data;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_ptr    = r_ptr;
        n_pos    = r_pos;
        n_hit    = r_hit;
        n_status = r_status;
        o_mem    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = i_cmd;
                    n_new  = i_entry;
                    n_data = '0;
                    n_lo   = '0;
                    n_hi   = r_count;
                    n_hit  = 1'b0;
                    n_pos  = '0;
                    unique case (i_cmd)
                        sli_pkg::CMD_PUT, sli_pkg::CMD_DELETE: begin
                            n_state = S_SEARCH;
                        end
                        sli_pkg::CMD_READ: begin
                            n_pos = w_read_pos;
                            if (w_read_pos < r_count) begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = i_read_position;
                                n_status    = sli_pkg::ST_INSERTED;
                                n_state     = S_READ_WAIT;
                            end else begin
                                n_status = sli_pkg::ST_BADPOS;
                                n_state  = S_REPLY;
                            end
                        end
                        default: begin
                            n_status = sli_pkg::ST_BADPOS;
                            n_state  = S_REPLY;
                        end
                    endcase
                end
            end
            // Binary search for the first entry whose key is not smaller.
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = w_mid[sli_pkg::ADDR_W-1:0];
                    n_state     = S_COMPARE;
                end else begin
                    n_pos = r_lo;
                    if (r_cmd == sli_pkg::CMD_PUT) begin
                        if (r_hit) begin
                            n_status = sli_pkg::ST_REPLACED;
                            n_state  = S_PUT_WR;
                        end else if (r_count == sli_pkg::MAX_CNT) begin
                            n_status = sli_pkg::ST_FULL;
                            n_state  = S_REPLY;
                        end else begin
                            n_status = sli_pkg::ST_INSERTED;
                            n_ptr    = r_count;
                            n_state  = (r_count == r_lo) ? S_PUT_WR : S_UP_RD;
                        end
                    end else begin
                        if (!r_hit) begin
                            n_status = sli_pkg::ST_ABSENT;
                            n_state  = S_REPLY;
                        end else begin
                            n_status = sli_pkg::ST_DELETED;
                            n_ptr    = r_lo;
                            if (w_lo_inc == r_count) begin
                                n_count = r_count - sli_pkg::CNT_W'(1);
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_DN_RD;
                            end
                        end
                    end
                end
            end
            S_COMPARE: begin
                // The last upper bound taken decides whether the key matched.
                if (i_rdata.key < r_new.key) begin
                    n_lo = w_mid_inc;
                end else begin
                    n_hi  = w_mid;
                    n_hit = (i_rdata.key == r_new.key);
                end
                n_state = S_SEARCH;
            end
            S_UP_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = w_ptr_dec[sli_pkg::ADDR_W-1:0];
                n_state     = S_UP_WR;
            end
            S_UP_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ptr[sli_pkg::ADDR_W-1:0];
                o_mem.wdata = i_rdata;
                n_ptr       = w_ptr_dec;
                n_state     = (w_ptr_dec == r_pos) ? S_PUT_WR : S_UP_RD;
            end
            S_PUT_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos[sli_pkg::ADDR_W-1:0];
                o_mem.wdata = r_new;
                if (r_status == sli_pkg::ST_INSERTED) begin
                    n_count = r_count + sli_pkg::CNT_W'(1);
                end
                n_state = S_REPLY;
            end
            S_DN_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = w_ptr_inc[sli_pkg::ADDR_W-1:0];
                n_state     = S_DN_WR;
            end
            S_DN_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ptr[sli_pkg::ADDR_W-1:0];
                o_mem.wdata = i_rdata;
                n_ptr       = w_ptr_inc;
                if (w_ptr_inc2 == r_count) begin
                    n_count = r_count - sli_pkg::CNT_W'(1);
                    n_state = S_REPLY;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_READ_WAIT: begin
                n_data  = i_rdata;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_new    <= n_new;
        r_data   <= n_data;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_hit    <= n_hit;
        r_status <= n_status;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_REPLY);
    assign o_res       = '{status: r_status, position: r_pos, count: r_count, data: r_data};

    assign w_insert_wr = (r_state == S_PUT_WR) && (r_status == sli_pkg::ST_INSERTED);

    `SLI_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= sli_pkg::MAX_CNT)
    `SLI_ASSERT_NOW(a_search_open, i_clk, i_rst_n, r_state == S_COMPARE, r_lo < r_hi)
    `SLI_ASSERT_NOW(a_up_above_pos, i_clk, i_rst_n, r_state == S_UP_WR, r_ptr > r_pos)
    `SLI_ASSERT_NOW(a_dn_in_range, i_clk, i_rst_n, r_state == S_DN_WR, w_ptr_inc < r_count)
    `SLI_ASSERT_NEXT(a_insert_counts, i_clk, i_rst_n, w_insert_wr, r_count == $past(r_count) + sli_pkg::CNT_W'(1))

endmodule

`default_nettype wire

// ===== rtl/sorted_line_index_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted line index table: keeps up to 1024 line entries (number, offset, length, hash)
// in ascending line-number order in one memory with one read and one write port.
// One word is worked on at a time and each gives exactly one result word. A put or a
// delete takes the word, runs a binary search with one memory read per probe and
// closes it; an insert or a delete then moves every later entry by one place, one
// entry at a time through the memory's single read port. An insert or a replace adds
// a final write, and every command then hands its result to the output register. The
// longest case is a delete at the head of a full table. A read fetches the entry at
// the given position, or reports a bad position if it lies beyond the count. The next
// input word is taken as soon as the previous result has moved to the output register,
// even while that result is still stalled there.
module sorted_line_index_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [30:0] i_line_number,
    input  wire logic [31:0] i_file_offset,
    input  wire logic [15:0] i_text_length,
    input  wire logic [31:0] i_text_hash,
    input  wire logic [9:0]  i_read_position,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [10:0]      o_position,
    output logic [10:0]      o_entry_count,
    output logic [30:0]      o_out_line_number,
    output logic [31:0]      o_out_offset,
    output logic [15:0]      o_out_length,
    output logic [31:0]      o_out_hash
);

    sli_pkg::t_entry   w_in_entry;
    sli_pkg::t_mem_req w_mem;
    sli_pkg::t_entry   w_rdata;
    sli_pkg::t_result  w_res;
    logic              w_res_valid;
    logic              w_take;

    logic              r_out_valid, n_out_valid;
    sli_pkg::t_result  r_out;

    assign w_in_entry = '{key: i_line_number, offset: i_file_offset,
                          length: i_text_length, hash: i_text_hash};

    sli_ram #(
        .WIDTH (sli_pkg::ENTRY_W),
        .DEPTH (sli_pkg::MAX_LINES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    sli_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (sli_pkg::t_cmd'(i_cmd)),
        .i_entry         (w_in_entry),
        .i_read_position (i_read_position),
        .o_mem           (w_mem),
        .i_rdata         (w_rdata),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res),
        .i_res_take      (w_take)
    );

    // The output register frees up when it is empty or its word is taken this cycle.
    assign w_take      = !r_out_valid || !i_stall;
    assign n_out_valid = w_take ? w_res_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_position        = r_out.position;
    assign o_entry_count     = r_out.count;
    assign o_out_line_number = r_out.data.key;
    assign o_out_offset      = r_out.data.offset;
    assign o_out_length      = r_out.data.length;
    assign o_out_hash        = r_out.data.hash;

endmodule

`default_nettype wire
